### hdl/fba_pkg.sv
// Shared constants, table entry layout and link types for the first-fit block allocator.
// No dependencies; every other file of the block imports this package.
package fba_pkg;

   localparam int ARENA_BYTES  = 1024;
   localparam int ALIGN_BYTES  = 16;
   localparam int HEADER_BYTES = 16;

   localparam int UNITS        = ARENA_BYTES / ALIGN_BYTES;
   localparam int UNIT_BITS    = $clog2(UNITS);
   localparam int ALIGN_SHIFT  = $clog2(ALIGN_BYTES);
   localparam int HDR_PAD      = ((HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
   localparam int HDR_UNITS    = HDR_PAD / ALIGN_BYTES;
   localparam int ARENA_USED   = UNITS * ALIGN_BYTES;
   localparam int RESET_SIZE   = (ARENA_USED > HDR_PAD) ? ARENA_USED - HDR_PAD : 0;

   // fixed field widths of the request and response words
   localparam int SIZE_W       = 10;
   localparam int ADDR_W       = SIZE_W + 1;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NO_FIT   = 2'd1,
      STATUS_BAD_FREE = 2'd2
   } status_type;

   // one block header: 12 bits
   typedef struct packed {
      logic              valid;
      logic              in_use;
      logic [SIZE_W-1:0] size;
   } entry_type;

   typedef struct packed {
      logic                 rd_en;
      logic [UNIT_BITS-1:0] rd_addr;
      logic                 wr_en;
      logic [UNIT_BITS-1:0] wr_addr;
      entry_type            wr_data;
   } tbl_req_type;

   typedef struct packed {
      status_type        status;
      logic [SIZE_W-1:0] data_offset;
   } res_type;

endpackage

### hdl/fba_if.sv
// Handshake channels of the allocator: request word in, response word out.
// Depends on fba_pkg for field widths and the status type.
interface fba_req_if
   import fba_pkg::*;
();
   logic              valid;
   logic              ready;
   logic              req_type;
   logic [SIZE_W-1:0] alloc_size;
   logic [SIZE_W-1:0] free_offset;

   modport source (output valid, output req_type, output alloc_size, output free_offset,
                   input ready);
   modport sink   (input valid, input req_type, input alloc_size, input free_offset,
                   output ready);
endinterface

interface fba_rsp_if
   import fba_pkg::*;
();
   logic              valid;
   logic              ready;
   status_type        status;
   logic [SIZE_W-1:0] data_offset;

   modport source (output valid, output status, output data_offset, input ready);
   modport sink   (input valid, input status, input data_offset, output ready);
endinterface

### hdl/fba_table.sv
// Block header table: one synchronous memory entry per arena unit, read data in the cycle after the read.
// Written flags in flops stand in for the reset contents. Depends on fba_pkg.
module fba_table
   import fba_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  tbl_req_type tbl,
   output entry_type   rd_data
);

   entry_type            mem_ff [UNITS];
   entry_type            rd_data_ff;
   logic [UNITS-1:0]     written_ff;
   logic                 rd_hit_ff;
   logic [UNIT_BITS-1:0] rd_addr_ff;
   entry_type            reset_entry;

   always_ff @(posedge clock) begin
      if (tbl.wr_en) begin
         mem_ff[tbl.wr_addr] <= tbl.wr_data;
      end
      if (tbl.rd_en) begin
         rd_data_ff <= mem_ff[tbl.rd_addr];
         rd_addr_ff <= tbl.rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
         rd_hit_ff  <= 1'b0;
      end else begin
         if (tbl.rd_en) begin
            rd_hit_ff <= written_ff[tbl.rd_addr];
         end
         if (tbl.wr_en) begin
            written_ff[tbl.wr_addr] <= 1'b1;
         end
      end
   end

   // untouched entries read as their reset contents: one free block spanning the arena
   always_comb begin
      reset_entry = '0;
      if (rd_addr_ff == '0) begin
         reset_entry.valid = 1'b1;
         reset_entry.size  = SIZE_W'(RESET_SIZE);
      end
      rd_data = rd_hit_ff ? rd_data_ff : reset_entry;
   end

`ifndef SYNTHESIS
   a_wr_valid_hdr : assert property (@(posedge clock) disable iff (reset)
      tbl.wr_en |-> tbl.wr_data.valid)
      else $error("table write without a valid header");

   a_rd_after_wr : assert property (@(posedge clock) disable iff (reset)
      tbl.wr_en ##1 (tbl.rd_en && tbl.rd_addr == $past(tbl.wr_addr))
      |=> rd_data == $past(tbl.wr_data, 2))
      else $error("table read misses a preceding write");
`endif

endmodule

### hdl/fba_walk.sv
// Request sequencer: first-fit walk over the header table, split and free updates.
// Depends on fba_pkg, fba_req_if and the fba_table read/write port.
module fba_walk
   import fba_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   fba_req_if.sink       req,
   output tbl_req_type   tbl,
   input  entry_type     rd_data,
   output logic          res_valid,
   output res_type       res,
   input  logic          res_ready
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ALLOC,
      ST_FREE,
      ST_SPLIT,
      ST_DONE
   } state_type;

   state_type            state_ff, state_in;
   logic [UNIT_BITS-1:0] u_ff, u_in;
   logic [SIZE_W-1:0]    size_ff, size_in;
   res_type              res_ff, res_in;
   logic [UNIT_BITS-1:0] split_addr_ff, split_addr_in;
   logic [SIZE_W-1:0]    split_size_ff, split_size_in;

   logic [ADDR_W-1:0]    pad_sum;
   logic [ADDR_W-1:0]    pad;
   logic [ADDR_W-1:0]    need;
   logic [ADDR_W-1:0]    data_start;
   logic                 fits;
   logic                 split;
   logic [UNIT_BITS+1:0] nu;
   logic [UNIT_BITS+1:0] nxt;
   logic [SIZE_W-1:0]    hdr_off;
   logic [UNIT_BITS:0]   hdr_unit;
   logic                 bad_off;

   always_comb begin
      // round the request up to whole units, then add a header
      pad_sum    = {1'b0, size_ff} + ADDR_W'(ALIGN_BYTES - 1);
      pad        = {pad_sum[ADDR_W-1:ALIGN_SHIFT], ALIGN_SHIFT'(0)};
      need       = pad + ADDR_W'(HDR_PAD);
      data_start = ADDR_W'({u_ff, ALIGN_SHIFT'(0)}) + ADDR_W'(HDR_PAD);
      fits       = !rd_data.in_use && (rd_data.size >= size_ff)
                   && (data_start < ADDR_W'(ARENA_USED));
      split      = need <= {1'b0, rd_data.size};
      nu         = (UNIT_BITS+2)'(u_ff) + (UNIT_BITS+2)'(need[ADDR_W-1:ALIGN_SHIFT]);
      nxt        = (UNIT_BITS+2)'(u_ff)
                   + (UNIT_BITS+2)'(rd_data.size[SIZE_W-1:ALIGN_SHIFT])
                   + (UNIT_BITS+2)'(HDR_UNITS);

      hdr_off    = req.free_offset - SIZE_W'(HDR_PAD);
      hdr_unit   = (UNIT_BITS+1)'(hdr_off[SIZE_W-1:ALIGN_SHIFT]);
      bad_off    = (req.free_offset < SIZE_W'(HDR_PAD))
                   || (hdr_off[ALIGN_SHIFT-1:0] != '0)
                   || (hdr_unit >= (UNIT_BITS+1)'(UNITS));
   end

   always_comb begin
      state_in      = state_ff;
      u_in          = u_ff;
      size_in       = size_ff;
      res_in        = res_ff;
      split_addr_in = split_addr_ff;
      split_size_in = split_size_ff;
      tbl           = '0;
      req.ready     = (state_ff == ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               size_in = req.alloc_size;
               res_in  = '{status: STATUS_OK, data_offset: '0};
               if (req.req_type == REQ_ALLOC) begin
                  tbl.rd_en    = 1'b1;
                  tbl.rd_addr  = '0;
                  u_in         = '0;
                  state_in     = ST_ALLOC;
               end else if (bad_off) begin
                  res_in.status = STATUS_BAD_FREE;
                  state_in      = ST_DONE;
               end else begin
                  tbl.rd_en    = 1'b1;
                  tbl.rd_addr  = hdr_unit[UNIT_BITS-1:0];
                  u_in         = hdr_unit[UNIT_BITS-1:0];
                  state_in     = ST_FREE;
               end
            end
         end
         ST_ALLOC: begin
            if (!rd_data.valid) begin
               res_in.status = STATUS_NO_FIT;
               state_in      = ST_DONE;
            end else if (fits) begin
               tbl.wr_en          = 1'b1;
               tbl.wr_addr        = u_ff;
               tbl.wr_data.valid  = 1'b1;
               tbl.wr_data.in_use = 1'b1;
               tbl.wr_data.size   = split ? pad[SIZE_W-1:0] : rd_data.size;
               res_in.data_offset = data_start[SIZE_W-1:0];
               split_addr_in      = nu[UNIT_BITS-1:0];
               split_size_in      = rd_data.size - need[SIZE_W-1:0];
               // if the block splits and the remainder starts inside the arena, its header goes in on the next cycle
               if (split && nu < (UNIT_BITS+2)'(UNITS)) begin
                  state_in = ST_SPLIT;
               end else begin
                  state_in = ST_DONE;
               end
            end else if (nxt >= (UNIT_BITS+2)'(UNITS)) begin
               res_in.status = STATUS_NO_FIT;
               state_in      = ST_DONE;
            end else begin
               tbl.rd_en   = 1'b1;
               tbl.rd_addr = nxt[UNIT_BITS-1:0];
               u_in        = nxt[UNIT_BITS-1:0];
            end
         end
         ST_SPLIT: begin
            tbl.wr_en          = 1'b1;
            tbl.wr_addr        = split_addr_ff;
            tbl.wr_data.valid  = 1'b1;
            tbl.wr_data.in_use = 1'b0;
            tbl.wr_data.size   = split_size_ff;
            state_in           = ST_DONE;
         end
         ST_FREE: begin
            if (!rd_data.valid) begin
               res_in.status = STATUS_BAD_FREE;
            end else begin
               tbl.wr_en          = 1'b1;
               tbl.wr_addr        = u_ff;
               tbl.wr_data.valid  = 1'b1;
               tbl.wr_data.in_use = 1'b0;
               tbl.wr_data.size   = rd_data.size;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the response register takes the word
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      res_valid = (state_ff == ST_DONE);
      res       = res_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      u_ff          <= u_in;
      size_ff       <= size_in;
      res_ff        <= res_in;
      split_addr_ff <= split_addr_in;
      split_size_ff <= split_size_in;
   end

`ifndef SYNTHESIS
   a_no_rd_wr_overlap : assert property (@(posedge clock) disable iff (reset)
      !(tbl.rd_en && tbl.wr_en))
      else $error("table read and write in the same cycle");

   a_split_elsewhere : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SPLIT) |-> (tbl.wr_addr != u_ff))
      else $error("split remainder overwrites the chosen block");
`endif

endmodule

### hdl/first_fit_block_allocator_top.sv
// Top level of the first-fit block allocator: sequencer, header table, response register.
// Depends on fba_pkg, fba_if, fba_table and fba_walk.
//
//   channel  dir  handshake     word
//   req      in   valid/ready   req_type, alloc_size, free_offset
//   rsp      out  valid/ready   status, data_offset
//
// Allocate: a first-fit walk that visits up to 64 headers, one table read
// per header; a split adds the remainder header write.
// Free: a rejected offset is answered without a table lookup; otherwise a table lookup and write.
// Reset: the table is usable at once; unwritten entries read as their reset contents.
// A new request word is taken while the previous response word still waits on rsp.
module first_fit_block_allocator_top
   import fba_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   fba_req_if.sink   req,
   fba_rsp_if.source rsp
);

   tbl_req_type tbl;
   entry_type   rd_data;
   logic        res_valid;
   res_type     res;
   logic        res_ready;
   logic        rsp_valid_ff;
   res_type     rsp_word_ff;

   fba_table u_table (
      .clock   (clock),
      .reset   (reset),
      .tbl     (tbl),
      .rd_data (rd_data)
   );

   fba_walk u_walk (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .tbl       (tbl),
      .rd_data   (rd_data),
      .res_valid (res_valid),
      .res       (res),
      .res_ready (res_ready)
   );

   assign res_ready = !rsp_valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ready) begin
         rsp_valid_ff <= res_valid;
      end
      if (res_ready && res_valid) begin
         rsp_word_ff <= res;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = rsp_word_ff.status;
   assign rsp.data_offset = rsp_word_ff.data_offset;

`ifndef SYNTHESIS
   a_fail_zero_offset : assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.status != STATUS_OK) |-> (rsp.data_offset == '0))
      else $error("failure response carries a nonzero offset");
`endif

endmodule
